@@ sv/lsp_pkg.sv @@
// Package for the lifetime slot pool: field widths, reset values,
// command and status codes, and the cell operation type.
// No dependencies; used by lsp_cell, lifetime_slot_pool_unit and the testbench.
package lsp_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int POOL_SLOTS_DEF = 64;
  localparam int LIFE_BITS_DEF  = 24;

  // Fixed field widths
  localparam int NEW_LIFE_W = 24;
  localparam int STEP_W     = 24;
  localparam int CFG_W      = 7;
  localparam int STAT_W     = 2;

  localparam logic [CFG_W-1:0] USABLE_RESET = 7'd64;

  // Request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_FRESH    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RECYCLED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FAILED   = 2'd2;
  localparam logic [STAT_W-1:0] ST_TICKED   = 2'd3;

  // Operation broadcast to every cell of the age row
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_TICK    = 3'd1,
    OP_COMPACT = 3'd2,
    OP_RECYCLE = 3'd3,
    OP_APPEND  = 3'd4
  } cell_op_t;

endpackage

@@ sv/lsp_lowest_set.sv @@
// Lowest set bit finder: isolates the lowest one with a single add,
// then encodes its position. Depends on nothing.
module lsp_lowest_set #(
  parameter int W  = 64,
  parameter int IW = $clog2(W)
) (
  input  logic [W-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  logic [W-1:0] onehot;

  // Isolate the lowest set bit
  assign onehot = vec & (~vec + W'(1));
  assign found  = |vec;

  // Encode the one-hot position
  always_comb begin
    idx = '0;
    for (int i = 0; i < W; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

@@ sv/lsp_cell.sv @@
// One cell of the age row: holds one live entry (slot index and remaining
// lifetime) and trades it with its neighbors. Depends on lsp_pkg.
module lsp_cell #(
  parameter int IDX_W     = 6,
  parameter int LIFE_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lsp_pkg::cell_op_t        op,
  input  logic [lsp_pkg::STEP_W-1:0] dt,
  input  logic [LIFE_BITS-1:0]     new_life,
  input  logic [IDX_W-1:0]         new_idx,
  input  logic [IDX_W-1:0]         head_idx,
  input  logic                     down_valid,
  input  logic                     up_valid,
  input  logic [IDX_W-1:0]         up_idx,
  input  logic [LIFE_BITS-1:0]     up_life,
  output logic                     valid,
  output logic [IDX_W-1:0]         idx,
  output logic [LIFE_BITS-1:0]     life,
  output logic                     expire
);

  localparam int CMP_W = (LIFE_BITS > lsp_pkg::STEP_W) ? LIFE_BITS : lsp_pkg::STEP_W;

  logic [CMP_W-1:0] life_ext;
  logic [CMP_W-1:0] dt_ext;
  logic [CMP_W-1:0] life_left;

  // Compare and subtract at the wider of the two widths
  assign life_ext  = CMP_W'(life);
  assign dt_ext    = CMP_W'(dt);
  assign life_left = life_ext - dt_ext;
  assign expire    = valid && (life_ext < dt_ext);

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        lsp_pkg::OP_TICK: begin
          if (expire) valid <= 1'b0;
        end
        lsp_pkg::OP_COMPACT: begin
          if (!valid && up_valid) valid <= 1'b1;
          else if (valid && !down_valid) valid <= 1'b0;
        end
        lsp_pkg::OP_APPEND: begin
          if (!valid && down_valid) valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    case (op)
      lsp_pkg::OP_TICK: begin
        if (valid && !expire) life <= LIFE_BITS'(life_left);
      end
      lsp_pkg::OP_COMPACT: begin
        // pull the neighbor down into a hole
        if (!valid && up_valid) begin
          idx  <= up_idx;
          life <= up_life;
        end
      end
      lsp_pkg::OP_RECYCLE: begin
        // rotate: shift down, the newest cell takes the old head
        if (valid) begin
          if (up_valid) begin
            idx  <= up_idx;
            life <= up_life;
          end else begin
            idx  <= head_idx;
            life <= new_life;
          end
        end
      end
      lsp_pkg::OP_APPEND: begin
        if (!valid && down_valid) begin
          idx  <= new_idx;
          life <= new_life;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/lifetime_slot_pool_unit.sv @@
// Lifetime slot pool: an allocate passes through S_ALLOC, which updates the age row and
// loads the result; a tick passes through S_TICK, then S_COMPACT until no hole is left in
// the age row (set by how far holes bubble through the cell chain), then loads the result.
// Requests are taken only in S_IDLE; a result held by m_tready stalls S_ALLOC or S_COMPACT
// until it leaves. Synchronous reset: all slots free, age row empty, usable_slots = 64.
// Depends on lsp_pkg, lsp_cell, lsp_lowest_set.
module lifetime_slot_pool_unit #(
  parameter int POOL_SLOTS = lsp_pkg::POOL_SLOTS_DEF,
  parameter int LIFE_BITS  = lsp_pkg::LIFE_BITS_DEF,
  parameter int IDX_W      = $clog2(POOL_SLOTS),
  parameter int CNT_W      = $clog2(POOL_SLOTS + 1),
  parameter int OUT_W      = ((IDX_W + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: usable_slots
  input  logic                            cfg_wen,
  input  logic [lsp_pkg::CFG_W-1:0]       cfg_wdata,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,  // new_life[23:0], time_step[47:24]
  input  logic                            s_tuser,  // cmd
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // slot_index, freed_count, live_count
  output logic [lsp_pkg::STAT_W-1:0]      m_tuser   // alloc_status
);

  localparam int CMPW = ((CNT_W > lsp_pkg::CFG_W) ? CNT_W : lsp_pkg::CFG_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_ALLOC   = 4'b0010,
    S_TICK    = 4'b0100,
    S_COMPACT = 4'b1000
  } state_t;

  state_t                      state;
  logic [lsp_pkg::CFG_W-1:0]   usable;
  logic [LIFE_BITS-1:0]        life_q;
  logic [lsp_pkg::STEP_W-1:0]  dt_q;
  logic [POOL_SLOTS-1:0]       slot_live;
  logic [POOL_SLOTS-1:0]       slot_live_next;
  logic [CNT_W-1:0]            live_total;

  logic [IDX_W-1:0]            out_idx;
  logic [lsp_pkg::STAT_W-1:0]  out_status;
  logic [CNT_W-1:0]            out_freed;
  logic [CNT_W-1:0]            out_live;

  // Age row signals
  lsp_pkg::cell_op_t           op;
  logic [POOL_SLOTS-1:0]       cell_valid;
  logic [IDX_W-1:0]            cell_idx    [POOL_SLOTS];
  logic [LIFE_BITS-1:0]        cell_life   [POOL_SLOTS];
  logic [POOL_SLOTS-1:0]       cell_expire;
  logic [POOL_SLOTS-1:0]       hole_under;

  logic [POOL_SLOTS-1:0]       limit_mask;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic                        empty_found;
  logic [IDX_W-1:0]            empty_idx;
  logic [CNT_W-1:0]            kept;

  logic                        out_free;
  logic                        settled;
  logic                        alloc_fail;
  logic                        alloc_fresh;
  logic                        result_load;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = OUT_W'({out_live, out_freed, out_idx});
  assign m_tuser  = out_status;

  // Slots below the usable limit
  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      limit_mask[i] = CMPW'(i) < CMPW'(usable);
    end
  end

  // Lowest free slot within the limit
  lsp_lowest_set #(.W(POOL_SLOTS), .IW(IDX_W)) u_free (
    .vec   (~slot_live & limit_mask),
    .found (free_found),
    .idx   (free_idx)
  );

  // First empty cell of the compacted row gives the surviving count
  lsp_lowest_set #(.W(POOL_SLOTS), .IW(IDX_W)) u_count (
    .vec   (~cell_valid),
    .found (empty_found),
    .idx   (empty_idx)
  );
  assign kept = empty_found ? CNT_W'(empty_idx) : CNT_W'(POOL_SLOTS);

  assign alloc_fail  = (usable == '0) || (!free_found && live_total == '0);
  assign alloc_fresh = !alloc_fail && free_found;

  // Detect an entry sitting above a hole
  always_comb begin
    hole_under = '0;
    for (int k = 0; k < POOL_SLOTS - 1; k++) begin
      hole_under[k] = !cell_valid[k] && cell_valid[k+1];
    end
  end
  assign settled = ~|hole_under;

  // Load a result when the output register is free
  assign result_load = out_free &&
                       ((state == S_ALLOC) || (state == S_COMPACT && settled));

  // Choose the row operation
  always_comb begin
    op = lsp_pkg::OP_HOLD;
    case (state)
      S_ALLOC: begin
        if (out_free && !alloc_fail) begin
          op = alloc_fresh ? lsp_pkg::OP_APPEND : lsp_pkg::OP_RECYCLE;
        end
      end
      S_TICK:    op = lsp_pkg::OP_TICK;
      S_COMPACT: if (!settled) op = lsp_pkg::OP_COMPACT;
      default:   op = lsp_pkg::OP_HOLD;
    endcase
  end

  // Chain of cells, oldest entry in cell 0
  for (genvar k = 0; k < POOL_SLOTS; k++) begin : g_cell
    logic                 down_v;
    logic                 up_v;
    logic [IDX_W-1:0]     up_i;
    logic [LIFE_BITS-1:0] up_l;

    if (k == 0) begin : g_first
      assign down_v = 1'b1;
    end else begin : g_down
      assign down_v = cell_valid[k-1];
    end

    if (k == POOL_SLOTS - 1) begin : g_last
      assign up_v = 1'b0;
      assign up_i = '0;
      assign up_l = '0;
    end else begin : g_up
      assign up_v = cell_valid[k+1];
      assign up_i = cell_idx[k+1];
      assign up_l = cell_life[k+1];
    end

    lsp_cell #(.IDX_W(IDX_W), .LIFE_BITS(LIFE_BITS)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .dt         (dt_q),
      .new_life   (life_q),
      .new_idx    (free_idx),
      .head_idx   (cell_idx[0]),
      .down_valid (down_v),
      .up_valid   (up_v),
      .up_idx     (up_i),
      .up_life    (up_l),
      .valid      (cell_valid[k]),
      .idx        (cell_idx[k]),
      .life       (cell_life[k]),
      .expire     (cell_expire[k])
    );
  end

  // Live bitmap: set on fresh allocate, drop expired slots on tick
  always_comb begin
    slot_live_next = slot_live;
    if (op == lsp_pkg::OP_APPEND) begin
      slot_live_next[free_idx] = 1'b1;
    end else if (op == lsp_pkg::OP_TICK) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        for (int k = 0; k < POOL_SLOTS; k++) begin
          if (cell_expire[k] && cell_idx[k] == IDX_W'(i)) slot_live_next[i] = 1'b0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      usable     <= lsp_pkg::USABLE_RESET;
      slot_live  <= '0;
      live_total <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      slot_live <= slot_live_next;
      if (cfg_wen) usable <= cfg_wdata;
      // Raise valid on a new result, drop it on handshake
      if (result_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= (s_tuser == lsp_pkg::CMD_TICK) ? S_TICK : S_ALLOC;
        end
        S_ALLOC: begin
          if (out_free) begin
            if (alloc_fresh) live_total <= live_total + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          state <= S_COMPACT;
        end
        S_COMPACT: begin
          if (settled && out_free) begin
            live_total <= kept;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture request fields
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      life_q <= LIFE_BITS'(s_tdata[lsp_pkg::NEW_LIFE_W-1:0]);
      dt_q   <= s_tdata[lsp_pkg::NEW_LIFE_W +: lsp_pkg::STEP_W];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_ALLOC && out_free) begin
      out_freed <= '0;
      if (alloc_fail) begin
        out_idx    <= '0;
        out_status <= lsp_pkg::ST_FAILED;
        out_live   <= live_total;
      end else if (alloc_fresh) begin
        out_idx    <= free_idx;
        out_status <= lsp_pkg::ST_FRESH;
        out_live   <= live_total + CNT_W'(1);
      end else begin
        out_idx    <= cell_idx[0];
        out_status <= lsp_pkg::ST_RECYCLED;
        out_live   <= live_total;
      end
    end else if (state == S_COMPACT && settled && out_free) begin
      out_idx    <= '0;
      out_status <= lsp_pkg::ST_TICKED;
      out_freed  <= live_total - kept;
      out_live   <= kept;
    end
  end

endmodule

@@ test/lifetime_slot_pool_unit_test.sv @@
// Testbench for lifetime_slot_pool_unit: allocate and tick requests checked
// against an in-bench model of the slot pool and its age order.
// Depends on lsp_pkg and the lifetime_slot_pool_unit RTL.
`timescale 1ns / 100ps

module lifetime_slot_pool_unit_test;

  localparam int POOL       = lsp_pkg::POOL_SLOTS_DEF;
  localparam int RES_W      = 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 80;
  localparam int HOLD_LEN   = 400;
  localparam int HOLD_AT    = 300;

  typedef struct packed {
    logic        cmd;
    logic [23:0] step;
    logic [23:0] life;
  } pool_req_t;

  typedef struct packed {
    logic [5:0] slot;
    logic [1:0] status;
    logic [6:0] freed;
    logic [6:0] live;
  } pool_result_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wen;
  logic [lsp_pkg::CFG_W-1:0] cfg_wdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [47:0]               s_tdata;   // new_life[23:0], time_step[47:24]
  logic                      s_tuser;   // cmd
  logic                      m_tvalid;
  logic                      m_tready;
  logic [RES_W-1:0]          m_tdata;   // slot_index[5:0], freed_count[12:6], live_count[19:13]
  logic [lsp_pkg::STAT_W-1:0] m_tuser;  // alloc_status

  lifetime_slot_pool_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Pool model state
  logic [23:0]               slot_life_m [POOL];
  logic                      slot_busy_m [POOL];
  logic [5:0]                age_line[$];
  logic [lsp_pkg::CFG_W-1:0] usable_m;

  pool_req_t    pending_req_q[$];
  pool_result_t expected_res_q[$];

  int queued_total;
  int accepted_total;
  int results_seen;
  int mismatch_count;
  int idle_cycles;
  int n_fresh, n_recycled, n_failed, n_ticks, n_expired;

  logic req_taken;
  int   burst_left, gap_left;
  int   hold_left, rx_mode, rx_timer;
  bit   hold_done;

  pool_result_t got, want;

  // Compute the result of one request and advance the pool model
  function automatic pool_result_t pool_apply(logic cmd, logic [23:0] life, logic [23:0] step);
    pool_result_t r;
    logic [5:0]   kept[$];
    int           limit;
    int           victim;
    int           i;
    r = '0;
    if (cmd == lsp_pkg::CMD_ALLOC) begin
      limit = (usable_m > POOL) ? POOL : usable_m;
      victim = -1;
      for (i = 0; i < limit && victim < 0; i++)
        if (!slot_busy_m[i]) victim = i;
      if (victim >= 0) begin
        slot_busy_m[victim] = 1'b1;
        slot_life_m[victim] = life;
        age_line.push_back(victim[5:0]);
        r.slot   = victim[5:0];
        r.status = lsp_pkg::ST_FRESH;
      end else if (limit != 0 && age_line.size() != 0) begin
        // recycle the oldest live slot; it becomes the newest
        r.slot = age_line.pop_front();
        age_line.push_back(r.slot);
        slot_life_m[r.slot] = life;
        r.status = lsp_pkg::ST_RECYCLED;
      end else begin
        r.status = lsp_pkg::ST_FAILED;
      end
    end else begin
      foreach (age_line[k]) begin
        if (slot_life_m[age_line[k]] < step) begin
          slot_busy_m[age_line[k]] = 1'b0;
          r.freed = r.freed + 7'd1;
        end else begin
          slot_life_m[age_line[k]] = slot_life_m[age_line[k]] - step;
          kept.push_back(age_line[k]);
        end
      end
      age_line = kept;
      r.status = lsp_pkg::ST_TICKED;
    end
    r.live = 7'(age_line.size());
    return r;
  endfunction

  // Clock
  always #5 clk = ~clk;

  // Request driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || req_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_req_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_req_q[0].cmd;
        s_tdata  <= {pending_req_q[0].step, pending_req_q[0].life};
        void'(pending_req_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern whose mode is redrawn at random when its timer runs out,
  // plus one long hold-off to back the block up
  always @(negedge clk) begin
    logic ready_nxt;
    ready_nxt = 1'b1;
    if (rst) begin
      ready_nxt = 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      ready_nxt = 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      ready_nxt = 1'b0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode  = $urandom_range(0, 2);
        rx_timer = $urandom_range(20, 80);
      end else begin
        rx_timer = rx_timer - 1;
      end
      case (rx_mode)
        0: ready_nxt = 1'b1;
        1: ready_nxt = 1'($urandom_range(0, 1));
        default: ready_nxt = (rx_timer % 4) != 3;
      endcase
    end
    m_tready <= ready_nxt;
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_res_q.push_back(pool_apply(s_tuser, s_tdata[23:0], s_tdata[47:24]));
        accepted_total = accepted_total + 1;
      end
      if (m_tvalid && m_tready) begin
        got.slot   = m_tdata[5:0];
        got.freed  = m_tdata[12:6];
        got.live   = m_tdata[19:13];
        got.status = m_tuser;
        results_seen = results_seen + 1;
        case (got.status)
          lsp_pkg::ST_FRESH:    n_fresh++;
          lsp_pkg::ST_RECYCLED: n_recycled++;
          lsp_pkg::ST_FAILED:   n_failed++;
          default: begin
            n_ticks++;
            n_expired = n_expired + got.freed;
          end
        endcase
        if (expected_res_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: slot %0d status %0d freed %0d live %0d",
                     got.slot, got.status, got.freed, got.live);
        end else begin
          want = expected_res_q.pop_front();
          if (got.slot !== want.slot || got.status !== want.status ||
              got.freed !== want.freed || got.live !== want.live) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at result %0d (expected/actual):", results_seen);
              $display("  slot %0d/%0d status %0d/%0d freed %0d/%0d live %0d/%0d",
                       want.slot, got.slot, want.status, got.status,
                       want.freed, got.freed, want.live, got.live);
            end
          end
        end
      end
      // Watchdog on stretches with no handshake at all
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_res_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic push_alloc(input logic [23:0] life);
    pool_req_t r;
    r.cmd  = lsp_pkg::CMD_ALLOC;
    r.life = life;
    r.step = 24'($urandom);
    pending_req_q.push_back(r);
    queued_total++;
  endtask

  task automatic push_tick(input logic [23:0] step);
    pool_req_t r;
    r.cmd  = lsp_pkg::CMD_TICK;
    r.life = 24'($urandom);
    r.step = step;
    pending_req_q.push_back(r);
    queued_total++;
  endtask

  // Wait until every request is accepted and answered, then let the block settle
  task automatic wait_drained();
    while (accepted_total != queued_total || expected_res_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write usable_slots while the block is idle
  task automatic write_usable(input logic [lsp_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    usable_m  = value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic run_random(input int count, input int alloc_pct);
    logic [23:0] v;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = 24'hFFFFFF;
          default: v = 24'($urandom);
        endcase
        push_alloc(v);
      end else begin
        case ($urandom_range(0, 7))
          0:       v = '0;
          1:       v = 24'($urandom);
          2, 3:    v = 24'($urandom_range(0, 255));
          default: v = 24'($urandom_range(0, 24'h3FFFF));
        endcase
        push_tick(v);
      end
    end
  endtask

  initial begin
    int limits [10];
    int pcts   [10];
    limits = '{64, 5, 1, 127, 0, 40, 2, 65, 17, 64};
    pcts   = '{80, 60, 55, 85, 50, 70, 60, 75, 65, 70};
    clk = 1'b0;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = lsp_pkg::CMD_ALLOC;
    m_tready = 1'b0;
    usable_m = lsp_pkg::USABLE_RESET;
    foreach (slot_busy_m[i]) begin
      slot_busy_m[i] = 1'b0;
      slot_life_m[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lifetime edges: zero life, full life, exact-zero survival, expiry
    push_alloc(24'h000000);
    push_alloc(24'hFFFFFF);
    push_alloc(24'h000100);
    push_tick(24'h000000);
    push_tick(24'h000100);
    push_tick(24'h000001);
    push_alloc(24'hABCDEF);
    push_tick(24'hFFFFFF);
    push_alloc(24'h010000);
    push_alloc(24'h020000);
    push_alloc(24'h030000);
    push_alloc(24'h040000);
    wait_drained();

    // Lowered limit: recycle oldest, including slots above the limit
    write_usable(7'd2);
    push_alloc(24'h111111);
    push_alloc(24'h222222);
    push_alloc(24'h333333);
    push_tick(24'h008000);
    wait_drained();

    // Zero limit: allocate fails
    write_usable(7'd0);
    push_alloc(24'h555555);
    push_tick(24'h000000);
    wait_drained();

    // Limit above the pool size
    write_usable(7'd127);
    push_alloc(24'h0000FF);
    push_alloc(24'hFF0000);
    push_tick(24'hFFFFFF);
    wait_drained();

    // Single usable slot: fresh then recycle of the same slot
    write_usable(7'd1);
    push_alloc(24'h7FFFFF);
    push_alloc(24'h800000);
    wait_drained();

    // Random phases across a range of limits
    for (int p = 0; p < 10; p++) begin
      write_usable(7'(limits[p]));
      run_random(193, pcts[p]);
      wait_drained();
    end

    $display("covered %0d requests: %0d fresh, %0d recycled, %0d failed allocates",
             accepted_total, n_fresh, n_recycled, n_failed);
    $display("%0d ticks expired %0d slots; %0d mismatches", n_ticks, n_expired, mismatch_count);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ lifetime_slot_pool_unit.f @@
sv/lsp_pkg.sv
sv/lsp_lowest_set.sv
sv/lsp_cell.sv
sv/lifetime_slot_pool_unit.sv
test/lifetime_slot_pool_unit_test.sv
